// File: hw/rtl/mnop_pkg.sv
// package: types, constants and pitch function for the note on/off pairing unit
`timescale 1ns / 1ps
package mnop_pkg;

  localparam int PENDING_DEPTH = 32;
  localparam int MAX_RESULTS   = 32;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    OP_NOTE_ON     = 3'd0,
    OP_NOTE_OFF    = 3'd1,
    OP_PROG_CHANGE = 3'd2,
    OP_OTHER_CHAN  = 3'd3,
    OP_NON_CHAN    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [27:0] delta_ticks;
    logic [6:0]  note_number;
    logic [6:0]  data_value;
    logic [3:0]  channel_number;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  key;
    logic [3:0]  note_channel;
    logic [6:0]  note_velocity;
    logic [6:0]  instrument;
    logic [31:0] start_tick;
    logic [31:0] end_tick;
    logic [21:0] frequency_q8;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  key;
    logic [3:0]  chan;
    logic [6:0]  vel;
    logic [6:0]  prog;
    logic [31:0] start;
  } entry_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic scan_req;
    logic at_end;
    logic hit;
    logic held;
    logic out_free;
  } sts_t;

  function automatic logic [21:0] pitch_q13(input logic [3:0] tone);
    logic [21:0] p;
    unique case (tone)
      4'd0:    p = 22'd2143273;
      4'd1:    p = 22'd2270659;
      4'd2:    p = 22'd2405663;
      4'd3:    p = 22'd2548777;
      4'd4:    p = 22'd2700329;
      4'd5:    p = 22'd2860892;
      4'd6:    p = 22'd3030958;
      4'd7:    p = 22'd3211182;
      4'd8:    p = 22'd3402138;
      4'd9:    p = 22'd3604480;
      4'd10:   p = 22'd3818783;
      4'd11:   p = 22'd4045865;
      default: p = 22'd0;
    endcase
    return p;
  endfunction

  // octave = key / 12 via reciprocal 43/512, exact for 7-bit keys
  function automatic logic [21:0] key_freq_q8(input logic [6:0] key);
    logic [12:0] prod;
    logic [3:0]  oct;
    logic [6:0]  tone;
    logic [31:0] shifted;
    prod    = 13'(key) * 13'd43;
    oct     = prod[12:9];
    tone    = key - 7'(oct) * 7'd12;
    shifted = {10'd0, pitch_q13(tone[3:0])} << oct;
    return shifted[31:10];
  endfunction

endpackage

// File: hw/rtl/midi_note_on_off_pairing_unit.sv
// top level of the midi note on/off pairing unit
// usage:
//   input channel: one midi track event per transfer (in_valid_i, in_stall_o,
//   in_item_i). output channel: one finished note per transfer (out_valid_o,
//   out_stall_i, out_item_o), the final note of a release has last set.
//   note-on, program change and ignored events are handled in idle. a release
//   scans the pending table one entry per cycle except while paused for the
//   output (registered ram read), then closes the scan and sends the last
//   held note from the flush state.
//   the first result of a release appears in the cycle after its second
//   match is found; the last one is sent by the flush state after the scan.
//   a matched note is held back one step so the last flag is known when it
//   leaves; the scan pauses while the output register is full and stalled.
//   in_stall_o is low only while no release is in progress.
//   reset clears tick count, program and pending count; table contents are
//   not cleared and are only read below the pending count.
`timescale 1ns / 1ps
module midi_note_on_off_pairing_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mnop_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mnop_pkg::out_item_t out_item_o
);
  import mnop_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mnop_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mnop_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_item_i  (in_item_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

// File: hw/rtl/mnop_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mnop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mnop_ctrl.sv
// controller state machine for event accept, table scan and final flush
`timescale 1ns / 1ps
module mnop_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mnop_pkg::sts_t sts_i,
  output mnop_pkg::cmd_t cmd_o
);
  import mnop_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.scan_req) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.at_end) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_FLUSH;
        end else if (!(sts_i.hit && sts_i.held && !sts_i.out_free)) begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!sts_i.held) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/mnop_dp.sv
// datapath: tick count, program, pending table, held note and output register
`timescale 1ns / 1ps
module mnop_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mnop_pkg::cmd_t      cmd_i,
  output mnop_pkg::sts_t      sts_o,
  input  mnop_pkg::in_item_t  in_item_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output mnop_pkg::out_item_t out_item_o
);
  import mnop_pkg::*;

  logic [31:0]      tick_q, tick_d, tick_sum;
  logic [32:0]      sum_wide;
  logic [6:0]       prog_q, prog_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] wr_q, wr_d;
  logic [RES_W-1:0] nres_q, nres_d;
  logic [6:0]       note_q;
  logic [21:0]      freq_q;
  entry_t           hold_q;
  logic             held_q, held_d;
  out_item_t        out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic   is_chan, is_on, is_release, emit_mid;
  logic   ram_we;
  logic   [IDX_W-1:0] ram_waddr;
  entry_t ram_wdata, ram_rdata;

  assign sum_wide   = {1'b0, tick_q} + 33'(in_item_i.delta_ticks);
  assign tick_sum   = sum_wide[32] ? '1 : sum_wide[31:0];
  assign is_chan    = in_item_i.operation <= OP_OTHER_CHAN;
  assign is_on      = (in_item_i.operation == OP_NOTE_ON) && (in_item_i.data_value != 7'd0);
  assign is_release = (in_item_i.operation == OP_NOTE_OFF) ||
                      ((in_item_i.operation == OP_NOTE_ON) && (in_item_i.data_value == 7'd0));

  assign sts_o.scan_req = is_release && (count_q != '0);
  assign sts_o.at_end   = rd_q == count_q;
  assign sts_o.hit      = (ram_rdata.key == note_q) && (nres_q != RES_W'(MAX_RESULTS));
  assign sts_o.held     = held_q;
  assign sts_o.out_free = !out_vld_q || !out_stall_i;

  assign emit_mid = cmd_i.step && sts_o.hit && held_q;

  always_comb begin
    tick_d    = tick_q;
    prog_d    = prog_q;
    count_d   = count_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    nres_d    = nres_q;
    held_d    = held_q;
    ram_we    = 1'b0;
    ram_waddr = wr_q[IDX_W-1:0];
    ram_wdata = ram_rdata;
    if (cmd_i.load) begin
      rd_d   = '0;
      wr_d   = '0;
      nres_d = '0;
      if (is_chan) begin
        tick_d = tick_sum;
      end
      if (in_item_i.operation == OP_PROG_CHANGE) begin
        prog_d = in_item_i.data_value;
      end
      if (is_on && (count_q != CNT_W'(PENDING_DEPTH))) begin
        ram_we    = 1'b1;
        ram_waddr = count_q[IDX_W-1:0];
        ram_wdata = '{key: in_item_i.note_number, chan: in_item_i.channel_number,
                      vel: in_item_i.data_value, prog: prog_q, start: tick_sum};
        count_d   = count_q + 1'b1;
      end
    end
    if (cmd_i.step) begin
      rd_d = rd_q + 1'b1;
      if (sts_o.hit) begin
        held_d = 1'b1;
        nres_d = nres_q + 1'b1;
      end else begin
        ram_we = 1'b1;
        wr_d   = wr_q + 1'b1;
      end
    end
    if (cmd_i.finish) begin
      count_d = wr_q;
    end
    if (cmd_i.flush) begin
      held_d = 1'b0;
    end
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (emit_mid || cmd_i.flush) begin
      out_d = '{key: hold_q.key, note_channel: hold_q.chan, note_velocity: hold_q.vel,
                instrument: hold_q.prog, start_tick: hold_q.start, end_tick: tick_q,
                frequency_q8: freq_q, last: cmd_i.flush};
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      prog_q    <= '0;
      count_q   <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      nres_q    <= '0;
      held_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      tick_q    <= tick_d;
      prog_q    <= prog_d;
      count_q   <= count_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      nres_q    <= nres_d;
      held_q    <= held_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      note_q <= in_item_i.note_number;
      freq_q <= key_freq_q8(in_item_i.note_number);
    end
    if (cmd_i.step && sts_o.hit) begin
      hold_q <= ram_rdata;
    end
    out_q <= out_d;
  end

  // read address follows the next scan index so data lines up with rd_q
  mnop_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(PENDING_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_d[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(PENDING_DEPTH))
    else $error("pending count above table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= rd_q)
    else $error("compaction write index passed read index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_mid || cmd_i.flush) |-> sts_o.out_free)
    else $error("output register overwritten while occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (count_q == $past(wr_q)) && held_q == $past(held_q))
    else $error("table count not updated at end of scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> !held_q && out_vld_q && out_q.last)
    else $error("final release not marked last");

endmodule
